// ===== design/bfdh_pkg.sv =====
// bfdh_pkg: shared types and constants for the double-hash bloom filter
// no dependencies; imported by bfdh_front, bfdh_mod, bfdh_back and the top level

package bfdh_pkg;

	localparam int HashW    = 64;
	localparam int WordW    = 64;
	localparam int IdxW     = 8;
	localparam int KindW    = 2;
	localparam int HalfW    = 32;
	localparam int BitSelW  = 6;
	// quotient bits of a probe index after the bit select is split off
	localparam int QuotW    = HalfW - BitSelW;
	// remainder unit retires this many quotient bits per cycle
	localparam int ModSteps = 2;
	localparam int ModCycles = QuotW / ModSteps;
	localparam int ModCntW  = $clog2(ModCycles + 1);
	localparam int CfgDataW = 9;
	localparam int WordsCfgW = 9;
	localparam int ProbesCfgW = 6;

	// operation codes
	localparam logic [KindW-1:0] KIND_ADD   = 2'd0;
	localparam logic [KindW-1:0] KIND_QUERY = 2'd1;
	localparam logic [KindW-1:0] KIND_LOAD  = 2'd2;
	localparam logic [KindW-1:0] KIND_READ  = 2'd3;

	// configuration register indexes
	localparam logic CFG_WORDS  = 1'b0;
	localparam logic CFG_PROBES = 1'b1;

	localparam logic [WordsCfgW-1:0]  WORDS_RESET  = 9'd256;
	localparam logic [ProbesCfgW-1:0] PROBES_RESET = 6'd4;

	// one queued command
	typedef struct packed {
		logic [KindW-1:0] kind;
		logic [HashW-1:0] hash;
		logic [IdxW-1:0]  widx;
		logic [WordW-1:0] wdata;
		logic             in_range;
	} cmd_t;

endpackage

// ===== design/bfdh_ram.sv =====
// bfdh_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module bfdh_ram #(
	parameter int Width = 64,
	parameter int Depth = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                       wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                       rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/bfdh_front.sv =====
// bfdh_front: accepts commands, tags word accesses with their range check,
// and holds them in a two-entry queue; depends on bfdh_pkg

module bfdh_front #(
	parameter int WW = 9
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bfdh_pkg::cmd_t in_cmd,
	input  logic [WW-1:0]  nw,
	output logic           full,
	output bfdh_pkg::cmd_t out_cmd,
	output logic           out_valid,
	input  logic           out_pop
);
	import bfdh_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	cmd_t       tagged_cmd;

	// classify: word access inside the words in use
	always_comb begin
		tagged_cmd = in_cmd;
		tagged_cmd.in_range = (32'(in_cmd.widx) < 32'(nw));
	end

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = slot_q[rp_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= tagged_cmd;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (out_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(out_pop);
		end
	end

endmodule

// ===== design/bfdh_mod.sv =====
// bfdh_mod: multi-cycle restoring remainder unit, two quotient bits per cycle
// depends on bfdh_pkg

module bfdh_mod #(
	parameter int WW = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bfdh_pkg::QuotW-1:0] dividend,
	input  logic [WW-1:0]             divisor,
	output logic                      done,
	output logic [WW-1:0]             rem
);
	import bfdh_pkg::*;

	logic [ModCntW-1:0] cnt_q;
	logic [QuotW-1:0]   dvd_q;
	logic [WW-1:0]      rem_q;
	logic               done_q;
	logic [WW-1:0]      rem_nxt;
	logic [QuotW-1:0]   dvd_nxt;

	// two restoring steps
	always_comb begin
		logic [WW:0] t;
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		for (int s = 0; s < ModSteps; s++) begin
			t = {rem_nxt, dvd_nxt[QuotW-1]};
			dvd_nxt = {dvd_nxt[QuotW-2:0], 1'b0};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			rem_nxt = t[WW-1:0];
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			rem_q  <= '0;
			dvd_q  <= '0;
		end else if (start) begin
			cnt_q  <= ModCntW'(ModCycles);
			done_q <= 1'b0;
			rem_q  <= '0;
			dvd_q  <= dividend;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - ModCntW'(1);
			done_q <= (cnt_q == ModCntW'(1));
			rem_q  <= rem_nxt;
			dvd_q  <= dvd_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== design/bfdh_back.sv =====
// bfdh_back: executes queued commands against the bit array, walks probes,
// holds the result register; depends on bfdh_pkg, bfdh_ram, bfdh_mod

module bfdh_back #(
	parameter int MAX_WORDS  = 256,
	parameter int WW = 9,
	parameter int PW = 6
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [WW-1:0]             nw,
	input  logic [PW-1:0]             np,
	input  bfdh_pkg::cmd_t            cmd,
	input  logic                      cmd_valid,
	output logic                      cmd_pop,
	output logic                      clearing,
	output logic                      res_valid,
	output logic                      res_present,
	output logic [bfdh_pkg::WordW-1:0] res_word,
	input  logic                      res_pop
);
	import bfdh_pkg::*;

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [AW-1:0]      clr_q;
	logic [KindW-1:0]   kind_q;
	logic [HalfW-1:0]   acc_q, lo_q;
	logic [PW-1:0]      pcnt_q;
	logic [BitSelW-1:0] bit_q;
	logic [AW-1:0]      waddr_q;
	logic               pres_q;
	logic [WordW-1:0]   word_q;
	logic               out_valid_q, out_present_q;
	logic [WordW-1:0]   out_word_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [WordW-1:0]   ram_wdata, ram_rdata;
	logic               mod_start, mod_done;
	logic [QuotW-1:0]   mod_dvd;
	logic [WW-1:0]      mod_rem;
	logic [HalfW-1:0]   acc_nxt;
	logic               probe_bit, out_free, last_probe;

	assign out_free   = !out_valid_q || res_pop;
	assign acc_nxt    = acc_q + lo_q;
	assign probe_bit  = ram_rdata[bit_q];
	assign last_probe = ((pcnt_q + PW'(1)) == np);
	assign clearing   = (state_q == ST_CLEAR);
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;

	bfdh_ram #(.Width(WordW), .Depth(MAX_WORDS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfdh_mod #(.WW(WW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dvd),
		.divisor  (nw),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// next state, memory port and remainder start
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = waddr_q;
		ram_wdata = ram_rdata | (WordW'(1) << bit_q);
		ram_raddr = AW'(mod_rem);
		mod_start = 1'b0;
		mod_dvd   = acc_nxt[HalfW-1:BitSelW];
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == AW'(MAX_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ram_waddr = AW'(cmd.widx);
				ram_wdata = cmd.wdata;
				ram_raddr = AW'(cmd.widx);
				mod_dvd   = cmd.hash[HashW-1:HalfW+BitSelW];
				if (cmd_valid) begin
					case (cmd.kind)
						KIND_ADD, KIND_QUERY: begin
							if (nw == '0 || np == '0) begin
								state_d = ST_DONE;
							end else begin
								mod_start = 1'b1;
								state_d   = ST_MOD;
							end
						end
						KIND_LOAD: begin
							ram_we  = cmd.in_range;
							state_d = ST_DONE;
						end
						default: begin
							state_d = cmd.in_range ? ST_RD : ST_DONE;
						end
					endcase
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				ram_we = (kind_q == KIND_ADD);
				if (kind_q == KIND_QUERY && !probe_bit) begin
					state_d = ST_DONE;
				end else if (last_probe) begin
					state_d = ST_DONE;
				end else begin
					mod_start = 1'b1;
					state_d   = ST_MOD;
				end
			end
			ST_RD: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res_pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working payload of the current command
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= cmd.kind;
				acc_q  <= cmd.hash[HashW-1:HalfW];
				lo_q   <= cmd.hash[HalfW-1:0];
				pcnt_q <= '0;
				pres_q <= 1'b0;
				word_q <= '0;
			end
			ST_MOD: begin
				waddr_q <= AW'(mod_rem);
				bit_q   <= acc_q[BitSelW-1:0];
			end
			ST_CHK: begin
				pcnt_q <= pcnt_q + PW'(1);
				acc_q  <= acc_nxt;
				if (kind_q == KIND_QUERY) begin
					pres_q <= probe_bit && last_probe;
				end
			end
			ST_RD: begin
				word_q <= ram_rdata;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_present_q <= pres_q;
			out_word_q    <= word_q;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_present = out_present_q;
	assign res_word    = out_word_q;

endmodule

// ===== design/bloom_filter_double_hash.sv =====
// bloom_filter_double_hash: top level of the double-hash bloom filter
// depends on bfdh_pkg, bfdh_front, bfdh_back (and through it bfdh_ram, bfdh_mod)
//
//   channel   signals                                   moves
//   input     push, full, kind, hash, word_index,       one command per transaction
//             word_data
//   result    empty, pop, present, read_word            one result per command
//   config    cfg_we, cfg_index, cfg_data               one register write
//
// add and query run the remainder unit (two quotient bits per cycle) for each
// probe, followed by one array access per probe: a read-modify-write for add
// and a read for query.
// after reset a clearing pass writes all MAX_WORDS words, one per cycle;
// full stays high meanwhile. a two-entry command queue and the result
// register let either side stall without stopping the other.

module bloom_filter_double_hash #(
	parameter int MAX_WORDS  = 256,
	parameter int MAX_PROBES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [bfdh_pkg::KindW-1:0]       kind,
	input  logic [bfdh_pkg::HashW-1:0]       hash,
	input  logic [bfdh_pkg::IdxW-1:0]        word_index,
	input  logic [bfdh_pkg::WordW-1:0]       word_data,
	output logic                             empty,
	input  logic                             pop,
	output logic                             present,
	output logic [bfdh_pkg::WordW-1:0]       read_word,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [bfdh_pkg::CfgDataW-1:0]    cfg_data
);
	import bfdh_pkg::*;

	localparam int WW = $clog2(MAX_WORDS + 1);
	localparam int PW = $clog2(MAX_PROBES + 1);

	logic [WordsCfgW-1:0]  words_q;
	logic [ProbesCfgW-1:0] probes_q;
	logic [31:0]           nw32, np32;
	logic [WW-1:0]         nw;
	logic [PW-1:0]         np;
	cmd_t                  in_cmd, q_cmd;
	logic                  front_full, q_valid, q_pop, clearing, res_valid, push_ok;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q  <= WORDS_RESET;
			probes_q <= PROBES_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_WORDS) begin
				words_q <= cfg_data[WordsCfgW-1:0];
			end else begin
				probes_q <= cfg_data[ProbesCfgW-1:0];
			end
		end
	end

	// saturate to the built sizes
	assign nw32 = (32'(words_q) > 32'(MAX_WORDS)) ? 32'(MAX_WORDS) : 32'(words_q);
	assign np32 = (32'(probes_q) > 32'(MAX_PROBES)) ? 32'(MAX_PROBES) : 32'(probes_q);
	assign nw   = nw32[WW-1:0];
	assign np   = np32[PW-1:0];

	assign full    = front_full || clearing;
	assign push_ok = push && !full;

	always_comb begin
		in_cmd.kind     = kind;
		in_cmd.hash     = hash;
		in_cmd.widx     = word_index;
		in_cmd.wdata    = word_data;
		in_cmd.in_range = 1'b0;
	end

	bfdh_front #(.WW(WW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_ok),
		.in_cmd    (in_cmd),
		.nw        (nw),
		.full      (front_full),
		.out_cmd   (q_cmd),
		.out_valid (q_valid),
		.out_pop   (q_pop)
	);

	bfdh_back #(
		.MAX_WORDS  (MAX_WORDS),
		.WW         (WW),
		.PW         (PW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.nw          (nw),
		.np          (np),
		.cmd         (q_cmd),
		.cmd_valid   (q_valid),
		.cmd_pop     (q_pop),
		.clearing    (clearing),
		.res_valid   (res_valid),
		.res_present (present),
		.res_word    (read_word),
		.res_pop     (pop && res_valid)
	);

	assign empty = !res_valid;

endmodule

// ===== design/bfdh_checker.sv =====
// bfdh_checker: port-level assertions for the bloom filter top level
// depends on bloom_filter_double_hash ports only; bound below

module bfdh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        present,
	input logic [63:0] read_word
);

	// a result never carries both a hit and a word
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(present && (read_word != 64'd0)))
		else $error("result has both present and read_word set");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(present) && $stable(read_word)))
		else $error("waiting result changed");

	// results leave only through a pop
	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("result dropped without pop");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (.*);
